FILE: hw/rtl/g2e_pkg.sv
// Shared widths, WGS-84 constants and the CORDIC arctangent table for the
// geodetic to ECEF converter. No dependencies.
package g2e_pkg;

   localparam int LAT_W = 31;
   localparam int LON_W = 32;
   localparam int ALT_W = 28;
   localparam int OUT_W = 34;

   localparam int MUL_W       = 64;   // operand bus of the rounding multiplier
   localparam int MUL_LATENCY = 4;    // abs, partial products, sum/round, sign
   localparam int ANG_W       = 36;   // radians, Q32
   localparam int Q40_W       = 44;   // Q40 fractions: trig, e2 terms, 1/sqrt
   localparam int LEN_W       = 44;   // radii in mm with 8 fraction bits

   localparam int CORDIC_ITERATIONS_DEF = 28;

   localparam logic signed [31:0] LAT_MAX = 32'sd754974720;
   localparam logic signed [31:0] LON_MAX = 32'sd1509949440;
   localparam logic signed [31:0] ALT_MIN = -32'sd1000000;
   localparam logic signed [31:0] ALT_MAX = 32'sd100000000;

   localparam logic signed [MUL_W-1:0] ONE_Q40          = 64'sd1099511627776;
   localparam logic signed [MUL_W-1:0] THREE_Q40        = 64'sd3298534883328;
   localparam logic signed [MUL_W-1:0] E2_Q40           = 64'sd7360548640;
   localparam logic signed [MUL_W-1:0] ONE_MINUS_E2_Q40 = 64'sd1092151079136;
   localparam logic signed [MUL_W-1:0] GAIN_Q40         = 64'sd667681663043;
   localparam logic signed [MUL_W-1:0] A_MM             = 64'sd6378137000;
   localparam logic signed [MUL_W-1:0] DEG2RAD_Q59      = 64'sd10061138136218226;

   // round(atan(2^-i) * 2^32); beyond the table atan(2^-i) is 2^-i to Q32
   function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
      logic signed [ANG_W-1:0] v;
      case (i)
         0:  v = 36'sd3373259426;
         1:  v = 36'sd1991351318;
         2:  v = 36'sd1052175346;
         3:  v = 36'sd534100635;
         4:  v = 36'sd268086748;
         5:  v = 36'sd134174063;
         6:  v = 36'sd67103403;
         7:  v = 36'sd33553749;
         8:  v = 36'sd16777131;
         9:  v = 36'sd8388597;
         10: v = 36'sd4194303;
         default: begin
            if (i <= 32) v = 36'sd1 <<< (32 - i);
            else v = '0;
         end
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/g2e_mul.sv
// Pipelined signed multiply, rounded right shift (ties away from zero).
// Four 32x32 partial products; depends on g2e_pkg.
module g2e_mul
   import g2e_pkg::*;
#(
   parameter int SHIFT = 40
) (
   input  logic                    clock,
   input  logic signed [MUL_W-1:0] op_a,
   input  logic signed [MUL_W-1:0] op_b,
   output logic signed [MUL_W-1:0] product
);

   localparam int HW = MUL_W / 2;
   localparam logic [2*MUL_W-1:0] RND = (2*MUL_W)'(1) << (SHIFT - 1);

   logic             neg1_ff, neg2_ff, neg3_ff;
   logic [MUL_W-1:0] ua_ff, ub_ff;
   logic [MUL_W-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [MUL_W-1:0] mag_ff;
   logic signed [MUL_W-1:0] prod_ff;
   logic [2*MUL_W-1:0] full_in;

   always_comb begin
      full_in = {{MUL_W{1'b0}}, p00_ff}
              + {{HW{1'b0}}, p01_ff, {HW{1'b0}}}
              + {{HW{1'b0}}, p10_ff, {HW{1'b0}}}
              + {p11_ff, {MUL_W{1'b0}}}
              + RND;
   end

   always_ff @(posedge clock) begin
      neg1_ff <= op_a[MUL_W-1] ^ op_b[MUL_W-1];
      ua_ff   <= op_a[MUL_W-1] ? MUL_W'(-op_a) : MUL_W'(op_a);
      ub_ff   <= op_b[MUL_W-1] ? MUL_W'(-op_b) : MUL_W'(op_b);

      neg2_ff <= neg1_ff;
      p00_ff  <= ua_ff[HW-1:0]     * ub_ff[HW-1:0];
      p01_ff  <= ua_ff[HW-1:0]     * ub_ff[MUL_W-1:HW];
      p10_ff  <= ua_ff[MUL_W-1:HW] * ub_ff[HW-1:0];
      p11_ff  <= ua_ff[MUL_W-1:HW] * ub_ff[MUL_W-1:HW];

      neg3_ff <= neg2_ff;
      mag_ff  <= MUL_W'(full_in >> SHIFT);

      prod_ff <= neg3_ff ? -signed'(mag_ff) : signed'(mag_ff);
   end

   assign product = prod_ff;

endmodule

FILE: hw/rtl/g2e_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration.
// Q32 angle in, Q40 cosine and sine out; depends on g2e_pkg.
module g2e_cordic
   import g2e_pkg::*;
#(
   parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic                    clock,
   input  logic signed [ANG_W-1:0] angle,
   output logic signed [Q40_W-1:0] cos_val,
   output logic signed [Q40_W-1:0] sin_val
);

   logic signed [Q40_W-1:0] x_ff [ITERATIONS];
   logic signed [Q40_W-1:0] y_ff [ITERATIONS];
   logic signed [ANG_W-1:0] z_ff [ITERATIONS];

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
      localparam logic signed [ANG_W-1:0] ATAN = atan_entry(i);
      logic signed [Q40_W-1:0] xp, yp;
      logic signed [ANG_W-1:0] zp;
      if (i == 0) begin : g_first
         assign xp = Q40_W'(GAIN_Q40);
         assign yp = '0;
         assign zp = angle;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (!zp[ANG_W-1]) begin
            x_ff[i] <= xp - (yp >>> i);
            y_ff[i] <= yp + (xp >>> i);
            z_ff[i] <= zp - ATAN;
         end else begin
            x_ff[i] <= xp + (yp >>> i);
            y_ff[i] <= yp - (xp >>> i);
            z_ff[i] <= zp + ATAN;
         end
      end
   end

   assign cos_val = x_ff[ITERATIONS-1];
   assign sin_val = y_ff[ITERATIONS-1];

endmodule

FILE: hw/rtl/geodetic_to_ecef_converter_top.sv
// Geodetic (WGS-84) to ECEF converter, fully pipelined fixed point.
// Depends on g2e_pkg, g2e_mul and g2e_cordic.
//
//  channel   ports                                   handshake
//  request   req_latitude, req_longitude,            start & !busy
//            req_altitude_mm
//  response  rsp_ecef_x_mm, rsp_ecef_y_mm,           rsp_valid, one cycle
//            rsp_ecef_z_mm
//
// One item enters per cycle; busy stays low since nothing in the pipe ever waits.
// Latency is set by the chain of rounding multipliers (deg->rad, sin^2, e2,
// two Newton steps of three multiplies each, N, then the final products)
// and the CORDIC.
// Synchronous reset clears only the valid line; data registers run free.
// The receiver cannot stall, so results leave on a single-cycle strobe.
module geodetic_to_ecef_converter_top
   import g2e_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [LAT_W-1:0] req_latitude,
   input  logic signed [LON_W-1:0] req_longitude,
   input  logic signed [ALT_W-1:0] req_altitude_mm,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_ecef_x_mm,
   output logic signed [OUT_W-1:0] rsp_ecef_y_mm,
   output logic signed [OUT_W-1:0] rsp_ecef_z_mm
);

   localparam int L      = MUL_LATENCY;
   // pipeline ages, counted in registers after the accepting edge
   localparam int T_Z    = 1 + L;                  // radians ready
   localparam int T_C    = T_Z + CORDIC_ITERATIONS;// sin/cos ready
   localparam int T_N0   = T_C + 2*L + 1;          // w and first 1/sqrt guess
   localparam int T_NWT  = 3*L + 1;                // one Newton step
   localparam int T_Q    = T_N0 + 2*T_NWT + L;     // N ready
   localparam int T_OUT  = T_Q + 2*L + 2;

   localparam int FLIP_DLY = T_C - 1;
   localparam int ALT_DLY  = T_Q + L - 1;
   localparam int CL_DLY   = T_Q + 1 - T_C;
   localparam int SL_DLY   = T_Q + L + 1 - T_C;
   localparam int CO_DLY   = T_Q + L - T_C;

   // ---------------- input stage: clamp, fold longitude into +-90 deg -------
   logic signed [LAT_W-1:0] lat_in, lat_ff;
   logic signed [LON_W-1:0] lon_cl, lon_in, lon_ff;
   logic signed [ALT_W-1:0] alt_in, alt_ff;
   logic                    flip_in, flip_ff;
   logic                    valid_ff [T_OUT];

   assign busy = 1'b0;

   always_comb begin
      if (req_latitude > LAT_MAX)       lat_in = LAT_W'(LAT_MAX);
      else if (req_latitude < -LAT_MAX) lat_in = LAT_W'(-LAT_MAX);
      else                              lat_in = req_latitude;

      if (req_longitude > LON_MAX)       lon_cl = LON_MAX;
      else if (req_longitude < -LON_MAX) lon_cl = -LON_MAX;
      else                               lon_cl = req_longitude;

      flip_in = 1'b0;
      lon_in  = lon_cl;
      if (lon_cl > LAT_MAX) begin
         lon_in  = lon_cl - LON_MAX;
         flip_in = 1'b1;
      end else if (lon_cl < -LAT_MAX) begin
         lon_in  = lon_cl + LON_MAX;
         flip_in = 1'b1;
      end

      if (req_altitude_mm > ALT_MAX)      alt_in = ALT_W'(ALT_MAX);
      else if (req_altitude_mm < ALT_MIN) alt_in = ALT_W'(ALT_MIN);
      else                                alt_in = req_altitude_mm;
   end

   always_ff @(posedge clock) begin
      lat_ff  <= lat_in;
      lon_ff  <= lon_in;
      alt_ff  <= alt_in;
      flip_ff <= flip_in;
   end

   // valid line travels beside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < T_OUT; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= start & ~busy;
         for (int k = 1; k < T_OUT; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // ---------------- degrees to Q32 radians ---------------------------------
   logic signed [MUL_W-1:0] zlat_p, zlon_p;

   g2e_mul #(.SHIFT(50)) u_rad_lat (
      .clock(clock), .op_a(MUL_W'(lat_ff)), .op_b(DEG2RAD_Q59), .product(zlat_p));
   g2e_mul #(.SHIFT(50)) u_rad_lon (
      .clock(clock), .op_a(MUL_W'(lon_ff)), .op_b(DEG2RAD_Q59), .product(zlon_p));

   // ---------------- sine and cosine -----------------------------------------
   logic signed [Q40_W-1:0] cl, sl, co, so;

   g2e_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_lat (
      .clock(clock), .angle(zlat_p[ANG_W-1:0]), .cos_val(cl), .sin_val(sl));
   g2e_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_lon (
      .clock(clock), .angle(zlon_p[ANG_W-1:0]), .cos_val(co), .sin_val(so));

   // folded longitude: cos and sin change sign
   logic                    flip_dly_ff [FLIP_DLY];
   logic signed [Q40_W-1:0] co_n_ff, so_n_ff;

   always_ff @(posedge clock) begin
      flip_dly_ff[0] <= flip_ff;
      for (int k = 1; k < FLIP_DLY; k++) flip_dly_ff[k] <= flip_dly_ff[k-1];
      co_n_ff <= flip_dly_ff[FLIP_DLY-1] ? -co : co;
      so_n_ff <= flip_dly_ff[FLIP_DLY-1] ? -so : so;
   end

   // ---------------- w = 1 - e2 sin^2(lat) ------------------------------------
   logic signed [MUL_W-1:0] s2_p, u_p;
   logic signed [Q40_W-1:0] w0_ff, y0_ff;

   g2e_mul #(.SHIFT(40)) u_sin_sq (
      .clock(clock), .op_a(MUL_W'(sl)), .op_b(MUL_W'(sl)), .product(s2_p));
   g2e_mul #(.SHIFT(40)) u_e2 (
      .clock(clock), .op_a(E2_Q40), .op_b(s2_p), .product(u_p));

   always_ff @(posedge clock) begin
      w0_ff <= Q40_W'(ONE_Q40 - u_p);
      y0_ff <= Q40_W'(ONE_Q40 + (u_p >>> 1));   // u is never negative
   end

   // ---------------- 1/sqrt(w): two Newton steps --------------------------------
   logic signed [Q40_W-1:0] y_stage [3];
   logic signed [Q40_W-1:0] w_stage [3];

   assign y_stage[0] = y0_ff;
   assign w_stage[0] = w0_ff;

   for (genvar n = 0; n < 2; n++) begin : g_newton
      logic signed [MUL_W-1:0] yy_p, wyy_p, yn_p;
      logic signed [Q40_W-1:0] w_dly_ff [T_NWT];
      logic signed [Q40_W-1:0] y_dly_ff [2*L+1];
      logic signed [Q40_W-1:0] c_ff;

      always_ff @(posedge clock) begin
         w_dly_ff[0] <= w_stage[n];
         for (int k = 1; k < T_NWT; k++) w_dly_ff[k] <= w_dly_ff[k-1];
         y_dly_ff[0] <= y_stage[n];
         for (int k = 1; k < 2*L+1; k++) y_dly_ff[k] <= y_dly_ff[k-1];
         c_ff <= Q40_W'(THREE_Q40 - wyy_p);
      end

      g2e_mul #(.SHIFT(40)) u_yy (
         .clock(clock), .op_a(MUL_W'(y_stage[n])), .op_b(MUL_W'(y_stage[n])),
         .product(yy_p));
      g2e_mul #(.SHIFT(40)) u_wyy (
         .clock(clock), .op_a(MUL_W'(w_dly_ff[L-1])), .op_b(yy_p), .product(wyy_p));
      g2e_mul #(.SHIFT(41)) u_ynew (
         .clock(clock), .op_a(MUL_W'(y_dly_ff[2*L])), .op_b(MUL_W'(c_ff)),
         .product(yn_p));

      assign y_stage[n+1] = Q40_W'(yn_p);
      assign w_stage[n+1] = w_dly_ff[T_NWT-1];
   end

   // ---------------- N and the two radii ---------------------------------------
   logic signed [MUL_W-1:0] nq_p, nb_p;
   logic signed [ALT_W+7:0] alt_dly_ff [ALT_DLY];
   logic signed [LEN_W-1:0] r1_ff, r2_ff;

   g2e_mul #(.SHIFT(32)) u_nq (
      .clock(clock), .op_a(A_MM), .op_b(MUL_W'(y_stage[2])), .product(nq_p));
   g2e_mul #(.SHIFT(40)) u_nb (
      .clock(clock), .op_a(nq_p), .op_b(ONE_MINUS_E2_Q40), .product(nb_p));

   always_ff @(posedge clock) begin
      alt_dly_ff[0] <= {alt_ff, 8'b0};
      for (int k = 1; k < ALT_DLY; k++) alt_dly_ff[k] <= alt_dly_ff[k-1];
      r1_ff <= LEN_W'(nq_p) + LEN_W'(alt_dly_ff[T_Q-2]);
      r2_ff <= LEN_W'(nb_p) + LEN_W'(alt_dly_ff[ALT_DLY-1]);
   end

   // ---------------- align trig terms with the radii ---------------------------
   logic signed [Q40_W-1:0] cl_dly_ff [CL_DLY];
   logic signed [Q40_W-1:0] sl_dly_ff [SL_DLY];
   logic signed [Q40_W-1:0] co_dly_ff [CO_DLY];
   logic signed [Q40_W-1:0] so_dly_ff [CO_DLY];

   always_ff @(posedge clock) begin
      cl_dly_ff[0] <= cl;
      for (int k = 1; k < CL_DLY; k++) cl_dly_ff[k] <= cl_dly_ff[k-1];
      sl_dly_ff[0] <= sl;
      for (int k = 1; k < SL_DLY; k++) sl_dly_ff[k] <= sl_dly_ff[k-1];
      co_dly_ff[0] <= co_n_ff;
      so_dly_ff[0] <= so_n_ff;
      for (int k = 1; k < CO_DLY; k++) begin
         co_dly_ff[k] <= co_dly_ff[k-1];
         so_dly_ff[k] <= so_dly_ff[k-1];
      end
   end

   // ---------------- final products --------------------------------------------
   logic signed [MUL_W-1:0] t_p, x_p, y_p, z_p;

   g2e_mul #(.SHIFT(40)) u_t (
      .clock(clock), .op_a(MUL_W'(r1_ff)), .op_b(MUL_W'(cl_dly_ff[CL_DLY-1])),
      .product(t_p));
   g2e_mul #(.SHIFT(48)) u_x (
      .clock(clock), .op_a(t_p), .op_b(MUL_W'(co_dly_ff[CO_DLY-1])), .product(x_p));
   g2e_mul #(.SHIFT(48)) u_y (
      .clock(clock), .op_a(t_p), .op_b(MUL_W'(so_dly_ff[CO_DLY-1])), .product(y_p));
   g2e_mul #(.SHIFT(48)) u_z (
      .clock(clock), .op_a(MUL_W'(r2_ff)), .op_b(MUL_W'(sl_dly_ff[SL_DLY-1])),
      .product(z_p));

   // output register, two's complement kept to the port width
   logic signed [OUT_W-1:0] x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      x_ff <= x_p[OUT_W-1:0];
      y_ff <= y_p[OUT_W-1:0];
      z_ff <= z_p[OUT_W-1:0];
   end

   assign rsp_valid     = valid_ff[T_OUT-1];
   assign rsp_ecef_x_mm = x_ff;
   assign rsp_ecef_y_mm = y_ff;
   assign rsp_ecef_z_mm = z_ff;

endmodule
